@@ rtl/tcst_pkg.sv @@
// Package for the touch contact slot tracker: word types, action and
// status codes, controller states and the controller/datapath interface.
package tcst_pkg;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_MOVE  = 3'd1,
    ACT_END   = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_HOVER = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_REVIVED  = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_TICKDONE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] contact_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        cancelled;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic [2:0]  status;
    logic [15:0] order;
    logic [15:0] ticks_held;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [1:0]  flags;
    logic [3:0]  active_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic search;
    logic apply;
  } dp_cmd_t;

endpackage

@@ rtl/touch_contact_slot_tracker_core.sv @@
// Touch contact slot tracker: top level joining controller and datapath.
// Depends on tcst_pkg, tcst_ctrl and tcst_dp.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_word_i) takes one event word:
//   start, move, end, tick or hover move. The output channel
//   (out_valid_o/out_ready_i/out_word_o) returns exactly one result word
//   per event.
//   Steps: an accepted word is loaded, then searched and applied; the
//   result word is registered before out_valid_o rises. The block then
//   holds the result until taken, and takes the next event the cycle
//   after, so it takes no new event until the last result is taken;
//   this is set by the single sequencer that owns the slot tables.
//   Reset clears every busy, ended and cancel flag, the hover table and
//   the appearance counter; no clearing pass is needed.
//   A stalled receiver holds the result word stable and keeps in_ready_o low.
module touch_contact_slot_tracker_core import tcst_pkg::*; #(
  parameter int TouchSlots = 8,
  parameter int HoverSlots = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  dp_cmd_t cmd;

  tcst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  tcst_dp #(.TouchSlots(TouchSlots), .HoverSlots(HoverSlots)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_word_i, .out_word_o
  );

endmodule

@@ rtl/tcst_ctrl.sv @@
// Controller state machine for the touch contact slot tracker.
// Depends on tcst_pkg.
module tcst_ctrl import tcst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_one_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_load_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.search) else $error("search must follow load");
  a_apply_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> out_valid_o) else $error("result must follow apply");

endmodule

@@ rtl/tcst_dp.sv @@
// Datapath of the touch contact slot tracker: slot and hover tables,
// id search, table update and result word. Depends on tcst_pkg.
module tcst_dp import tcst_pkg::*; #(
  parameter int TouchSlots = 8,
  parameter int HoverSlots = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_word_t  in_word_i,
  output out_word_t out_word_o
);

  localparam int TW = (TouchSlots > 1) ? $clog2(TouchSlots) : 1;
  localparam int HW = (HoverSlots > 1) ? $clog2(HoverSlots) : 1;

  logic [TouchSlots-1:0] busy_q, ended_q, cancel_q;
  logic [31:0] ident_q [TouchSlots];
  logic [15:0] order_q [TouchSlots];
  logic [15:0] ticks_q [TouchSlots];
  logic [31:0] start_q [TouchSlots];
  logic [31:0] prev_q  [TouchSlots];
  logic [31:0] cur_q   [TouchSlots];
  logic [15:0] seq_q;
  logic [HoverSlots-1:0] hbusy_q;
  logic [31:0] hident_q [HoverSlots];

  in_word_t in_q;
  logic          hit_q, free_q, hhit_q, hfree_q;
  logic [TW-1:0] hit_idx_q, free_idx_q;
  logic [HW-1:0] hhit_idx_q, hfree_idx_q;
  out_word_t     out_q;

  logic          hit_d, free_d, hhit_d, hfree_d;
  logic [TW-1:0] hit_idx_d, free_idx_d;
  logic [HW-1:0] hhit_idx_d, hfree_idx_d;
  logic          want_ended;
  logic [31:0]   pos;

  assign pos        = {in_q.pos_y, in_q.pos_x};
  assign want_ended = (in_q.action == ACT_START);

  always_comb begin
    hit_d = 1'b0; hit_idx_d = '0; free_d = 1'b0; free_idx_d = '0;
    for (int s = TouchSlots - 1; s >= 0; s--) begin
      if (busy_q[s] && ended_q[s] == want_ended && ident_q[s] == in_q.contact_id) begin
        hit_d = 1'b1; hit_idx_d = TW'(s);
      end
      if (!busy_q[s]) begin
        free_d = 1'b1; free_idx_d = TW'(s);
      end
    end
    hhit_d = 1'b0; hhit_idx_d = '0; hfree_d = 1'b0; hfree_idx_d = '0;
    for (int h = HoverSlots - 1; h >= 0; h--) begin
      if (hbusy_q[h] && hident_q[h] == in_q.contact_id) begin
        hhit_d = 1'b1; hhit_idx_d = HW'(h);
      end
      if (!hbusy_q[h]) begin
        hfree_d = 1'b1; hfree_idx_d = HW'(h);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_word_i;
    if (cmd_i.search) begin
      hit_q <= hit_d; hit_idx_q <= hit_idx_d;
      free_q <= free_d; free_idx_q <= free_idx_d;
      hhit_q <= hhit_d; hhit_idx_q <= hhit_idx_d;
      hfree_q <= hfree_d; hfree_idx_q <= hfree_idx_d;
    end
  end

  // Next table state and result for the apply step.
  logic [TouchSlots-1:0] busy_d, ended_d, cancel_d;
  logic [15:0]   seq_d;
  logic [HoverSlots-1:0] hbusy_d;
  logic          touch_wr, tick_wr, hover_wr, new_slot, reset_pos;
  logic [TW-1:0] ts;
  logic [HW-1:0] hs;
  logic [2:0]    status;
  logic          emit_touch, emit_hover;
  logic [TW:0]   live_n;
  out_word_t     res;

  always_comb begin
    busy_d = busy_q; ended_d = ended_q; cancel_d = cancel_q;
    seq_d = seq_q; hbusy_d = hbusy_q;
    touch_wr = 1'b0; tick_wr = 1'b0; hover_wr = 1'b0;
    new_slot = 1'b0; reset_pos = 1'b0;
    ts = hit_idx_q; hs = hhit_idx_q;
    status = ST_NOTFOUND; emit_touch = 1'b0; emit_hover = 1'b0;
    case (in_q.action)
      ACT_START: begin
        if (hit_q) begin
          ended_d[ts] = 1'b0; cancel_d[ts] = 1'b0;
          touch_wr = 1'b1; reset_pos = (ticks_q[ts] == '0);
          status = ST_REVIVED; emit_touch = 1'b1;
        end else if (free_q) begin
          ts = free_idx_q;
          busy_d[ts] = 1'b1; ended_d[ts] = 1'b0; cancel_d[ts] = 1'b0;
          seq_d = seq_q + 16'd1;
          touch_wr = 1'b1; new_slot = 1'b1; reset_pos = 1'b1;
          status = ST_NEW; emit_touch = 1'b1;
        end else status = ST_FULL;
      end
      ACT_MOVE: if (hit_q) begin
        touch_wr = 1'b1; reset_pos = (ticks_q[ts] == '0);
        status = ST_UPDATED; emit_touch = 1'b1;
      end
      ACT_END: if (hit_q) begin
        ended_d[ts] = 1'b1; cancel_d[ts] = in_q.cancelled;
        touch_wr = 1'b1;
        status = ST_UPDATED; emit_touch = 1'b1;
      end
      ACT_TICK: begin
        tick_wr = 1'b1;
        busy_d = busy_q & ~ended_q;
        ended_d = '0;
        if ((busy_q & ~ended_q) == '0) seq_d = '0;
        status = ST_TICKDONE;
      end
      ACT_HOVER: begin
        if (hhit_q) begin
          hover_wr = 1'b1; status = ST_UPDATED; emit_hover = 1'b1;
        end else if (hfree_q) begin
          hs = hfree_idx_q; hbusy_d[hs] = 1'b1;
          hover_wr = 1'b1; status = ST_NEW; emit_hover = 1'b1;
        end else status = ST_FULL;
      end
      default: ;
    endcase
    live_n = '0;
    for (int s = 0; s < TouchSlots; s++)
      live_n = live_n + (TW+1)'(busy_d[s] & ~ended_d[s]);
    res = '0;
    res.status = status;
    res.active_count = 4'(live_n);
    if (emit_touch) begin
      res.slot       = 3'(ts);
      res.order      = new_slot ? seq_q : order_q[ts];
      res.ticks_held = new_slot ? 16'd0 : ticks_q[ts];
      res.start_x    = reset_pos ? in_q.pos_x : start_q[ts][15:0];
      res.start_y    = reset_pos ? in_q.pos_y : start_q[ts][31:16];
      res.prev_x     = reset_pos ? in_q.pos_x : prev_q[ts][15:0];
      res.prev_y     = reset_pos ? in_q.pos_y : prev_q[ts][31:16];
      res.cur_x      = in_q.pos_x;
      res.cur_y      = in_q.pos_y;
      res.flags      = {cancel_d[ts], ended_d[ts]};
    end
    if (emit_hover) begin
      res.slot  = 3'(hs);
      res.cur_x = in_q.pos_x;
      res.cur_y = in_q.pos_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0; ended_q <= '0; cancel_q <= '0; seq_q <= '0; hbusy_q <= '0;
    end else if (cmd_i.apply) begin
      busy_q <= busy_d; ended_q <= ended_d; cancel_q <= cancel_d;
      seq_q <= seq_d; hbusy_q <= hbusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_q <= res;
      if (touch_wr) begin
        cur_q[ts] <= pos;
        if (reset_pos) begin
          start_q[ts] <= pos; prev_q[ts] <= pos;
        end
        if (new_slot) begin
          ident_q[ts] <= in_q.contact_id; order_q[ts] <= seq_q; ticks_q[ts] <= '0;
        end
      end
      if (tick_wr) begin
        for (int s = 0; s < TouchSlots; s++)
          if (busy_q[s] && !ended_q[s]) begin
            prev_q[s] <= cur_q[s];
            if (ticks_q[s] != 16'hFFFF) ticks_q[s] <= ticks_q[s] + 16'd1;
          end
      end
      if (hover_wr) hident_q[hs] <= in_q.contact_id;
    end
  end

  assign out_word_o = out_q;

  a_ended_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ended_q & ~busy_q) == '0) else $error("ended slot not busy");
  a_tick_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && in_q.action == ACT_TICK) |=> ended_q == '0)
    else $error("tick left ended slot");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.apply) |-> out_q.active_count == 4'($countones(busy_q & ~ended_q)))
    else $error("active count mismatch");

endmodule

@@ bench/touch_contact_slot_tracker_core_tb.sv @@
// Self-checking bench for touch_contact_slot_tracker_core: drives event words
// through valid/ready and compares each result word with a built-in predictor.
// Depends on tcst_pkg and the tracker RTL.
module touch_contact_slot_tracker_core_tb;
  import tcst_pkg::*;

  localparam int NT = 8;
  localparam int NH = 8;
  localparam int IDLE_LIMIT = 5000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  touch_contact_slot_tracker_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  // tracker shadow state
  logic        t_busy [NT];
  logic        t_ended [NT];
  logic        t_canc [NT];
  logic [31:0] t_id [NT];
  logic [15:0] t_ord [NT];
  logic [15:0] t_ticks [NT];
  logic [31:0] t_start [NT];
  logic [31:0] t_prev [NT];
  logic [31:0] t_cur [NT];
  logic [15:0] seq_num;
  logic        h_busy [NH];
  logic [31:0] h_id [NH];

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        errors;
  int        idle_cycles;
  int        hold_off;
  bit        stim_done;
  bit        burst_on;
  int        burst_left;
  bit        drain_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_word_t touch_view(int s, status_e st);
    out_word_t r;
    r = '0;
    r.slot = 3'(s);
    r.status = st;
    r.order = t_ord[s];
    r.ticks_held = t_ticks[s];
    r.start_x = t_start[s][15:0];
    r.start_y = t_start[s][31:16];
    r.prev_x = t_prev[s][15:0];
    r.prev_y = t_prev[s][31:16];
    r.cur_x = t_cur[s][15:0];
    r.cur_y = t_cur[s][31:16];
    r.flags = {t_canc[s], t_ended[s]};
    return r;
  endfunction

  function automatic out_word_t track_event(in_word_t w);
    out_word_t r;
    logic [31:0] p;
    int s;
    int hit;
    int live;
    r = '0;
    r.status = ST_NOTFOUND;
    p = {w.pos_y, w.pos_x};
    hit = -1;
    case (w.action)
      ACT_START: begin
        for (s = NT - 1; s >= 0; s--)
          if (t_busy[s] && t_ended[s] && t_id[s] == w.contact_id) hit = s;
        if (hit >= 0) begin
          t_ended[hit] = 1'b0;
          t_canc[hit] = 1'b0;
          if (t_ticks[hit] == 0) begin
            t_start[hit] = p;
            t_prev[hit] = p;
          end
          t_cur[hit] = p;
          r = touch_view(hit, ST_REVIVED);
        end else begin
          for (s = NT - 1; s >= 0; s--)
            if (!t_busy[s]) hit = s;
          if (hit >= 0) begin
            t_busy[hit] = 1'b1;
            t_ended[hit] = 1'b0;
            t_canc[hit] = 1'b0;
            t_id[hit] = w.contact_id;
            t_ord[hit] = seq_num;
            seq_num++;
            t_ticks[hit] = '0;
            t_start[hit] = p;
            t_prev[hit] = p;
            t_cur[hit] = p;
            r = touch_view(hit, ST_NEW);
          end else r.status = ST_FULL;
        end
      end
      ACT_MOVE, ACT_END: begin
        for (s = NT - 1; s >= 0; s--)
          if (t_busy[s] && !t_ended[s] && t_id[s] == w.contact_id) hit = s;
        if (hit >= 0) begin
          if (w.action == ACT_MOVE) begin
            if (t_ticks[hit] == 0) begin
              t_start[hit] = p;
              t_prev[hit] = p;
            end
          end else begin
            t_ended[hit] = 1'b1;
            t_canc[hit] = w.cancelled;
          end
          t_cur[hit] = p;
          r = touch_view(hit, ST_UPDATED);
        end
      end
      ACT_TICK: begin
        live = 0;
        for (s = 0; s < NT; s++)
          if (t_busy[s]) begin
            if (t_ended[s]) t_busy[s] = 1'b0;
            else begin
              t_prev[s] = t_cur[s];
              if (t_ticks[s] != 16'hFFFF) t_ticks[s]++;
              live++;
            end
          end
        if (live == 0) seq_num = '0;
        r.status = ST_TICKDONE;
      end
      ACT_HOVER: begin
        for (s = NH - 1; s >= 0; s--)
          if (h_busy[s] && h_id[s] == w.contact_id) hit = s;
        if (hit >= 0) r.status = ST_UPDATED;
        else begin
          for (s = NH - 1; s >= 0; s--)
            if (!h_busy[s]) hit = s;
          if (hit >= 0) begin
            h_busy[hit] = 1'b1;
            h_id[hit] = w.contact_id;
            r.status = ST_NEW;
          end else r.status = ST_FULL;
        end
        if (hit >= 0) begin
          r.slot = 3'(hit);
          r.cur_x = w.pos_x;
          r.cur_y = w.pos_y;
        end
      end
      default: ;
    endcase
    live = 0;
    for (s = 0; s < NT; s++)
      if (t_busy[s] && !t_ended[s]) live++;
    r.active_count = 4'(live);
    return r;
  endfunction

  function automatic in_word_t mk(logic [2:0] a, logic [31:0] id, logic [15:0] x,
                                  logic [15:0] y, logic c);
    in_word_t w;
    w.action = a;
    w.contact_id = id;
    w.pos_x = x;
    w.pos_y = y;
    w.cancelled = c;
    return w;
  endfunction

  function automatic logic [15:0] rnd_pos();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rnd_id(int pool);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return 32'($urandom_range(0, pool)) ^ 32'hA5A5_0000;
  endfunction

  task automatic add_word(in_word_t w);
    pending_words.push_back(w);
  endtask

  task automatic fill_stimulus();
    int i;
    int n;
    int pool;
    logic [2:0] a;
    add_word(mk(ACT_TICK, 0, 0, 0, 0));
    add_word(mk(ACT_MOVE, 32'd5, 0, 0, 0));
    add_word(mk(ACT_END, 32'd5, 0, 0, 1));
    for (i = 0; i < 9; i++)
      add_word(mk(ACT_START, (i == 8) ? 32'hFFFF_FFFF : 32'(i), 16'h8000 + 16'(i),
                  16'h7FFF - 16'(i), 0));
    add_word(mk(ACT_START, 32'd0, 0, 0, 0));
    add_word(mk(ACT_MOVE, 32'd1, 16'h7FFF, 16'h8000, 0));
    add_word(mk(ACT_END, 32'd2, 16'h1234, 16'hFEDC, 1));
    add_word(mk(ACT_END, 32'd3, 16'h0001, 16'h0002, 0));
    add_word(mk(ACT_START, 32'd2, 16'h5555, 16'hAAAA, 0));
    add_word(mk(ACT_TICK, 0, 0, 0, 0));
    add_word(mk(ACT_MOVE, 32'd4, 16'h0F0F, 16'hF0F0, 0));
    add_word(mk(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1));
    add_word(mk(3'd7, 0, 0, 0, 0));
    for (i = 0; i < 9; i++) add_word(mk(ACT_HOVER, 32'(100 + i), 16'(i), 16'(-i), 0));
    while (pending_words.size() < 1700) begin
      pool = ($urandom_range(0, 3) == 0) ? 40 : 12;
      n = $urandom_range(0, 99);
      if (n < 6) add_word(mk(3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                             16'($urandom), 1'($urandom)));
      else begin
        if (n < 28) a = ACT_START;
        else if (n < 55) a = ACT_MOVE;
        else if (n < 72) a = ACT_END;
        else if (n < 88) a = ACT_TICK;
        else a = ACT_HOVER;
        add_word(mk(a, rnd_id(pool), rnd_pos(), rnd_pos(), 1'($urandom)));
      end
      // long run of moves and ticks to reach saturation region rarely is not practical;
      // hold ticks in bursts to age contacts
      if ($urandom_range(0, 199) == 0)
        for (i = 0; i < 30; i++) add_word(mk(ACT_TICK, 0, 0, 0, 0));
    end
  endtask

  initial begin
    int s;
    rst_ni = 1'b0;
    errors = 0;
    stim_done = 1'b0;
    drain_req = 1'b0;
    for (s = 0; s < NT; s++) begin
      t_busy[s] = 0; t_ended[s] = 0; t_canc[s] = 0;
    end
    for (s = 0; s < NH; s++) h_busy[s] = 0;
    seq_num = '0;
    fill_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      burst_on <= 1'b1;
      burst_left <= 10;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(track_event(in_word_i));
        void'(pending_words.pop_front());
        if (pending_words.size() == 1000) drain_req <= 1'b1;
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (drain_req && expected_results.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        if (drain_req) drain_req <= 1'b0;
        if (burst_left == 0) begin
          burst_on <= !burst_on;
          burst_left <= burst_on ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end else burst_left <= burst_left - 1;
        if (burst_on && pending_words.size() != 0) begin
          in_valid_i <= 1'b1;
          in_word_i <= pending_words[0];
        end else begin
          in_valid_i <= 1'b0;
          if (pending_words.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    out_word_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_off <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_word_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (e !== out_word_o) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_word_o);
            errors++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pending_words.size() == 1400 && hold_off == 0) hold_off <= 300;
      if (hold_off > 1) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (hold_off == 1) hold_off <= -1;
        case (($time / 2400) % 3)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  initial begin
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (stim_done && expected_results.size() == 0) begin
        repeat (20) @(posedge clk_i);
        if (errors == 0 && !out_valid_o) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
